FILE: rtl/pdf_keyword_scan_classifier_top_assert.svh
// Assertion macros for the PDF keyword scan classifier.
// Used by pdf_keyword_scan_classifier_top; needs a clock i_clk and reset i_rst_n in scope.
`ifndef PDF_KEYWORD_SCAN_CLASSIFIER_TOP_ASSERT_SVH
`define PDF_KEYWORD_SCAN_CLASSIFIER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define PKSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define PKSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pksc_pkg.sv
// Shared constants, types and helpers of the PDF keyword scan classifier.
// No dependencies; imported by every module of the block.
package pksc_pkg;

    // Counter and window geometry
    localparam int CNT_W  = 32;
    localparam int WIN    = 10;
    localparam int NPAT   = 18;
    localparam int NCNT   = 17;
    localparam int NREP   = 15;
    localparam int IDX_W  = 4;
    localparam int CIW    = $clog2(NCNT);

    // Counter slots that feed the verdict but are not reported
    localparam int IDX_OBJ  = 15;
    localparam int IDX_NREF = 16;

    // Report queue depth
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Verdict codes
    localparam logic [1:0] V_GOOD    = 2'd0;
    localparam logic [1:0] V_MAL     = 2'd1;
    localparam logic [1:0] V_NOT_PDF = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [WIN*8-1:0] t_pat;

    // Patterns, right aligned: the last character sits in the low byte
    localparam t_pat PAT_TEXT [NPAT] = '{
        t_pat'("endobj"),
        t_pat'("OpenAction"),
        t_pat'("JavaScript"),
        t_pat'("Launch"),
        t_pat'("RichMedia"),
        t_pat'("ndstream"),
        t_pat'("startxref"),
        t_pat'({8'h0A, "xref", 8'h0A}),
        t_pat'("AcroForm"),
        t_pat'("Encrypt"),
        t_pat'("JBIG2Deco"),
        t_pat'("ObjStm"),
        t_pat'("/JS "),
        t_pat'("Page"),
        t_pat'("[/FlateDec"),
        t_pat'(" obj"),
        t_pat'({" n", 8'h0D}),
        t_pat'(" n ")
    };

    localparam int PAT_LEN [NPAT] = '{
        6, 10, 10, 6, 9, 8, 9, 6, 8, 7, 9, 6, 4, 4, 10, 4, 3, 3
    };

    // File header, first character in the top byte
    localparam logic [3:0][7:0] HDR_TEXT = "%PDF";

    // One finished file as handed from the scanner to the reporter
    typedef struct packed {
        logic [NCNT-1:0][CNT_W-1:0] cnt;
        t_cnt                       pos;
        logic                       hdr_ok;
    } t_report;

    function automatic t_cnt f_sat_inc(t_cnt v);
        return (&v) ? v : v + t_cnt'(1);
    endfunction

endpackage

FILE: rtl/pksc_front.sv
// Scanner: byte window, parallel pattern compare, header check and saturating counters.
// Depends on pksc_pkg; writes one t_report per file into the report queue.
module pksc_front import pksc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic          i_full,
    output logic          o_wr,
    output t_report       o_report
);

    logic [WIN-2:0][7:0]        r_win;
    logic [WIN-2:0]             r_wv;
    t_cnt                       r_pos;
    logic                       r_hm;
    logic [NCNT-1:0][CNT_W-1:0] r_cnt;

    logic [NCNT-1:0][CNT_W-1:0] n_cnt;
    t_cnt                       n_pos;
    logic                       n_hm;

    logic                       w_acc;
    logic [WIN*8-1:0]           w_cur;
    logic [WIN-1:0]             w_vv;
    logic [NPAT-1:0]            w_m;
    logic [NCNT-1:0]            w_hit;
    logic                       w_hdr_bad;

    assign w_acc = i_push && !i_full;
    assign w_cur = {r_win, i_data_byte};
    assign w_vv  = {r_wv, 1'b1};

    // Compare every pattern against the newest bytes of the window
    for (genvar p = 0; p < NPAT; p++) begin : g_pat
        localparam int L = PAT_LEN[p];
        logic [WIN*8-1:0] w_diff;
        assign w_diff = w_cur ^ PAT_TEXT[p];
        assign w_m[p] = (w_diff[8*L-1:0] == '0) && (&w_vv[L-1:0]);
    end

    // Both " n" forms share one counter
    assign w_hit = {w_m[IDX_NREF+1] | w_m[IDX_NREF], w_m[IDX_NREF-1:0]};

    always_comb begin
        for (int c = 0; c < NCNT; c++) begin
            n_cnt[c] = w_hit[c] ? f_sat_inc(r_cnt[c]) : r_cnt[c];
        end
    end

    // Drop header match on the first differing byte among the first four
    assign w_hdr_bad = (r_pos[CNT_W-1:2] == '0) &&
                       (i_data_byte != HDR_TEXT[2'd3 - r_pos[1:0]]);
    assign n_hm  = r_hm && !w_hdr_bad;
    assign n_pos = f_sat_inc(r_pos);

    // Hand the finished file to the queue on its last byte
    assign o_wr            = w_acc && i_last_byte;
    assign o_report.cnt    = n_cnt;
    assign o_report.pos    = n_pos;
    assign o_report.hdr_ok = n_hm && (n_pos[CNT_W-1:2] != '0);

    // Advance per-file state, clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv  <= '0;
            r_pos <= '0;
            r_hm  <= 1'b1;
            r_cnt <= '0;
        end else if (w_acc) begin
            if (i_last_byte) begin
                r_wv  <= '0;
                r_pos <= '0;
                r_hm  <= 1'b1;
                r_cnt <= '0;
            end else begin
                r_wv  <= {r_wv[WIN-3:0], 1'b1};
                r_pos <= n_pos;
                r_hm  <= n_hm;
                r_cnt <= n_cnt;
            end
        end
    end

    // Shift the byte window
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_win <= {r_win[WIN-3:0], i_data_byte};
        end
    end

endmodule

FILE: rtl/pksc_queue.sv
// Short queue of finished file reports between scanner and reporter.
// Depends on pksc_pkg for t_report and the queue depth.
module pksc_queue import pksc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_report i_wdata,
    input  logic    i_rd,
    output logic    o_full,
    output logic    o_nempty,
    output t_report o_head
);

    t_report          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;

    logic             w_wr;
    logic             w_rd;

    assign o_full   = (r_cnt == QCW'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];

    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && o_nempty;

    // Store a report at the write pointer
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/pksc_back.sv
// Reporter: turns the oldest queued report into items, one per cycle while popped.
// Depends on pksc_pkg; reads the head of pksc_queue and drives the result register.
module pksc_back import pksc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_report          i_head,
    input  logic             i_nempty,
    output logic             o_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [IDX_W-1:0] o_item_index,
    output logic [31:0]      o_item_value,
    output logic [1:0]       o_verdict,
    output logic             o_header_valid,
    output logic             o_last_result
);

    logic [IDX_W-1:0] r_idx;
    logic             r_ovld;
    logic [IDX_W-1:0] r_item_index;
    logic [31:0]      r_item_value;
    logic [1:0]       r_verdict;
    logic             r_header_valid;
    logic             r_last_result;

    logic             w_load;
    logic             w_last;
    logic [1:0]       w_verdict;
    t_cnt             w_val;
    t_cnt             w_endobj;
    t_cnt             w_oa;
    t_cnt             w_js;
    t_cnt             w_obj;
    t_cnt             w_nref;

    assign w_endobj = i_head.cnt[0];
    assign w_oa     = i_head.cnt[1];
    assign w_js     = i_head.cnt[2];
    assign w_obj    = i_head.cnt[IDX_OBJ];
    assign w_nref   = i_head.cnt[IDX_NREF];

    // Classify the file from its counters
    always_comb begin
        if (!i_head.hdr_ok) begin
            w_verdict = V_NOT_PDF;
        end else if (w_endobj != w_obj) begin
            w_verdict = V_MAL;
        end else if ((w_oa != '0) || (w_js != '0)) begin
            w_verdict = (w_js != '0) ? V_MAL : V_GOOD;
        end else if ((w_endobj > w_nref) || (w_nref == '0)) begin
            w_verdict = V_MAL;
        end else begin
            w_verdict = V_GOOD;
        end
    end

    // Select the byte count or a keyword counter
    assign w_val  = (r_idx == '0) ? i_head.pos : i_head.cnt[CIW'(r_idx) - CIW'(1)];
    assign w_last = !i_head.hdr_ok || (r_idx == IDX_W'(NREP));

    // Load the next item whenever the result register is free or being taken
    assign w_load = i_nempty && (!r_ovld || i_pop);
    assign o_rd   = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx  <= w_last ? '0 : r_idx + 1'b1;
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item_index   <= r_idx;
            r_item_value   <= w_val;
            r_verdict      <= w_verdict;
            r_header_valid <= i_head.hdr_ok;
            r_last_result  <= w_last;
        end
    end

    assign o_empty        = !r_ovld;
    assign o_item_index   = r_item_index;
    assign o_item_value   = r_item_value;
    assign o_verdict      = r_verdict;
    assign o_header_valid = r_header_valid;
    assign o_last_result  = r_last_result;

endmodule

FILE: rtl/pdf_keyword_scan_classifier_top.sv
// PDF keyword scan classifier: takes one file byte per request and reports keyword
// counts and a verdict per file. One byte is accepted every cycle while full is low; the
// scanner compares all 17 keywords in parallel over a ten byte window, so its rate is
// one byte per cycle. On the last byte of a file the counts go to a two entry report
// queue; the reporter then gives 16 result items (one for a bad or short header), one per
// cycle while popped. full rises only while both queue entries hold unfinished reports,
// so files shorter than about 16 bytes can outpace the reporter and see stalls.
// Depends on pksc_pkg, pksc_front, pksc_queue, pksc_back and the assertion header.
module pdf_keyword_scan_classifier_top import pksc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_item_index,
    output logic [31:0] o_item_value,
    output logic [1:0]  o_verdict,
    output logic        o_header_valid,
    output logic        o_last_result
);

    logic    w_wr;
    t_report w_wdata;
    logic    w_rd;
    logic    w_nempty;
    t_report w_head;

    // Scan bytes and build per-file reports
    pksc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_wr        (w_wr),
        .o_report    (w_wdata)
    );

    // Buffer finished reports
    pksc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_wdata  (w_wdata),
        .i_rd     (w_rd),
        .o_full   (full),
        .o_nempty (w_nempty),
        .o_head   (w_head)
    );

    // Emit result items
    pksc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_nempty       (w_nempty),
        .o_rd           (w_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_item_index   (o_item_index),
        .o_item_value   (o_item_value),
        .o_verdict      (o_verdict),
        .o_header_valid (o_header_valid),
        .o_last_result  (o_last_result)
    );

`include "pdf_keyword_scan_classifier_top_assert.svh"

    // A report ends either on the last counter or on a rejected header
    `PKSC_ASSERT_NOW(a_last_item, !empty && o_last_result, (o_item_index == 4'(NREP)) || (o_verdict == V_NOT_PDF), "report ended early")

    // The not-a-pdf verdict goes with a rejected header and nothing else
    `PKSC_ASSERT_NOW(a_hdr_verdict, !empty, (o_verdict == V_NOT_PDF) == !o_header_valid, "verdict and header flag disagree")

    // Inside a report the next item follows at once with the next index
    `PKSC_ASSERT_NEXT(a_idx_step, pop && !empty && !o_last_result, !empty && (o_item_index == $past(o_item_index) + 4'd1), "report items out of sequence")

endmodule
